// ===== design/lrts_pkg.sv =====
// Shared types and constants for the longest-remaining-time scheduler.
package lrts_pkg;

  localparam int unsigned SLOTS     = 16;
  localparam int unsigned TIME_BITS = 16;
  localparam int unsigned SLOT_W    = $clog2(SLOTS);
  localparam int unsigned NOW_W     = 24;
  localparam int unsigned SUM_W     = 26;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  slot;
    logic [15:0] arrival_time;
    logic [15:0] burst_time;
  } lrts_in_t;

  typedef struct packed {
    logic [23:0] tick_time;
    logic        busy_res;
    logic [3:0]  run_slot;
    logic [15:0] remaining_after;
    logic        finished;
    logic [23:0] completion_time;
    logic [23:0] turnaround;
    logic [23:0] waiting;
    logic [25:0] turnaround_sum;
    logic [25:0] waiting_sum;
    logic        all_done;
  } lrts_out_t;

  typedef struct packed {
    logic                 loaded;
    logic                 ready;
    logic [TIME_BITS-1:0] arrival;
    logic [TIME_BITS-1:0] burst;
    logic [TIME_BITS-1:0] remaining;
  } slot_rec_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

// ===== design/longest_remaining_time_scheduler_top.sv =====
// Top level of the longest-remaining-time-first scheduler: cell ring and tick sequencer.
//
//   channel   handshake                  payload
//   command   start / busy (in)          in_word_i  (lrts_in_t)
//   result    res_valid_o strobe (out)   res_o      (lrts_out_t)
//
// Load and clear words are taken while idle; busy stays low.
// During a tick word the slot ring rotates once through the head to admit and pick,
// once more to decrement and check completion, then ST_CALC and ST_FIN do the
// turnaround/waiting arithmetic. The result strobes the cycle after ST_FIN.
// Reset empties every slot and zeroes time and sums. The receiver cannot stall.
module longest_remaining_time_scheduler_top import lrts_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  lrts_in_t  in_word_i,
  output logic      res_valid_o,
  output lrts_out_t res_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_CALC,
    ST_FIN
  } state_e;

  state_e               state_q;
  logic [SLOT_W-1:0]    cnt_q;
  logic                 found_q;
  logic [SLOT_W-1:0]    best_idx_q;
  logic [TIME_BITS-1:0] best_rem_q, best_arr_q, best_burst_q;
  logic                 done_q;
  logic [NOW_W-1:0]     now_q, tat_q;
  logic [SUM_W-1:0]     tat_sum_q, wait_sum_q;
  lrts_out_t            res_q;
  logic                 res_valid_q;

  slot_rec_t cells [SLOTS];
  slot_rec_t head_new, load_rec;
  cell_ctl_t ctl [SLOTS];
  logic      accept, take, head_live, finished, last;
  logic [NOW_W-1:0] ct, wt;
  logic [SUM_W:0]   tat_sum_w, wait_sum_w;

  assign accept = start && (state_q == ST_IDLE);
  assign last   = (cnt_q == SLOT_W'(SLOTS - 1));

  always_comb begin
    load_rec.loaded    = 1'b1;
    load_rec.ready     = 1'b0;
    load_rec.arrival   = TIME_BITS'(in_word_i.arrival_time);
    load_rec.burst     = TIME_BITS'(in_word_i.burst_time);
    load_rec.remaining = TIME_BITS'(in_word_i.burst_time);
  end

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    always_comb begin
      ctl[i].clr   = accept && (in_word_i.cmd == CMD_CLEAR);
      ctl[i].load  = accept && (in_word_i.cmd == CMD_LOAD) && (32'(in_word_i.slot) == i);
      ctl[i].shift = (state_q == ST_SCAN) || (state_q == ST_UPDATE);
    end
    if (i == SLOTS - 1) begin : g_tail
      lrts_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctl_i      (ctl[i]),
        .load_rec_i (load_rec),
        .shift_rec_i(head_new),
        .rec_o      (cells[i])
      );
    end else begin : g_body
      lrts_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctl_i      (ctl[i]),
        .load_rec_i (load_rec),
        .shift_rec_i(cells[i+1]),
        .rec_o      (cells[i])
      );
    end
  end

  // head of the ring: admission and pick in the first pass, run-slot update in the second
  always_comb begin
    head_new = cells[0];
    if (state_q == ST_SCAN) begin
      if (cells[0].loaded && !cells[0].ready && (cells[0].remaining != '0) &&
          (NOW_W'(cells[0].arrival) == now_q)) begin
        head_new.ready = 1'b1;
      end
    end else if (state_q == ST_UPDATE) begin
      if (found_q && (cnt_q == best_idx_q)) begin
        head_new.remaining = cells[0].remaining - TIME_BITS'(1);
        if (head_new.remaining == '0) begin
          head_new.ready = 1'b0;
        end
      end
    end
  end

  assign take = head_new.ready &&
                (!found_q || (head_new.remaining > best_rem_q) ||
                 ((head_new.remaining == best_rem_q) && (head_new.arrival < best_arr_q)));
  assign head_live = head_new.loaded && (head_new.remaining != '0);

  assign finished   = found_q && (best_rem_q == TIME_BITS'(1));
  assign ct         = now_q + NOW_W'(1);
  assign wt         = tat_q - NOW_W'(best_burst_q);
  assign tat_sum_w  = {1'b0, tat_sum_q} + (SUM_W + 1)'(tat_q);
  assign wait_sum_w = {1'b0, wait_sum_q} + (SUM_W + 1)'(wt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      found_q      <= 1'b0;
      best_idx_q   <= '0;
      best_rem_q   <= '0;
      best_arr_q   <= '0;
      best_burst_q <= '0;
      done_q       <= 1'b1;
      now_q        <= '0;
      tat_q        <= '0;
      tat_sum_q    <= '0;
      wait_sum_q   <= '0;
      res_q        <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (in_word_i.cmd)
              CMD_TICK: begin
                state_q <= ST_SCAN;
                cnt_q   <= '0;
                found_q <= 1'b0;
                done_q  <= 1'b1;
              end
              CMD_CLEAR: begin
                now_q      <= '0;
                tat_sum_q  <= '0;
                wait_sum_q <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (take) begin
            found_q      <= 1'b1;
            best_idx_q   <= cnt_q;
            best_rem_q   <= head_new.remaining;
            best_arr_q   <= head_new.arrival;
            best_burst_q <= head_new.burst;
          end
          cnt_q <= last ? '0 : cnt_q + SLOT_W'(1);
          if (last) begin
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (head_live) begin
            done_q <= 1'b0;
          end
          cnt_q <= last ? '0 : cnt_q + SLOT_W'(1);
          if (last) begin
            state_q <= ST_CALC;
          end
        end
        ST_CALC: begin
          tat_q   <= ct - NOW_W'(best_arr_q);
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          res_q.tick_time       <= now_q;
          res_q.busy_res        <= found_q;
          res_q.run_slot        <= found_q ? 4'(best_idx_q) : 4'd0;
          res_q.remaining_after <= found_q ? 16'(best_rem_q - TIME_BITS'(1)) : 16'd0;
          res_q.finished        <= finished;
          res_q.completion_time <= finished ? ct : '0;
          res_q.turnaround      <= finished ? tat_q : '0;
          res_q.waiting         <= finished ? wt : '0;
          res_q.all_done        <= done_q;
          if (finished) begin
            tat_sum_q  <= tat_sum_w[SUM_W] ? '1 : tat_sum_w[SUM_W-1:0];
            wait_sum_q <= wait_sum_w[SUM_W] ? '1 : wait_sum_w[SUM_W-1:0];
            res_q.turnaround_sum <= tat_sum_w[SUM_W] ? '1 : tat_sum_w[SUM_W-1:0];
            res_q.waiting_sum    <= wait_sum_w[SUM_W] ? '1 : wait_sum_w[SUM_W-1:0];
          end else begin
            res_q.turnaround_sum <= tat_sum_q;
            res_q.waiting_sum    <= wait_sum_q;
          end
          now_q       <= ct;
          res_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy        = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy)
    else $error("result strobe while busy");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe longer than one cycle");

  a_fin_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.finished) |-> (res_o.busy_res && (res_o.remaining_after == '0)))
    else $error("finished word without a run slot at zero");

  a_tick_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALC) |-> ($past(state_q) == ST_UPDATE))
    else $error("arithmetic stage entered without update pass");

endmodule

// ===== design/lrts_cell.sv =====
// One slot cell of the scheduler ring: holds a slot record, clears, loads or passes it on.
module lrts_cell import lrts_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_ctl_t ctl_i,
  input  slot_rec_t load_rec_i,
  input  slot_rec_t shift_rec_i,
  output slot_rec_t rec_o
);

  slot_rec_t rec_q, rec_d;

  always_comb begin
    rec_d = rec_q;
    if (ctl_i.clr) begin
      rec_d.loaded = 1'b0;
      rec_d.ready  = 1'b0;
    end else if (ctl_i.load) begin
      rec_d = load_rec_i;
    end else if (ctl_i.shift) begin
      rec_d = shift_rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= '0;
    end else begin
      rec_q <= rec_d;
    end
  end

  assign rec_o = rec_q;

endmodule
